### hw/rtl/gpcf_pkg.sv
// Shared types, constants and codes of the gamma pair coincidence filter.
// No dependencies; gpcf_hit_mem, gpcf_pair_seq and the top level import this package.
package gpcf_pkg;

    // Hit store geometry
    localparam int MAX_HITS = 16;
    localparam int HIT_AW   = $clog2(MAX_HITS);
    localparam int CNT_W    = HIT_AW + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOM_LIMIT    = 3'd0,
        CFG_ENERGY_LIMIT = 3'd1,
        CFG_PROMPT_WIN   = 3'd2,
        CFG_COINC_WIN    = 3'd3,
        CFG_PAIR_LIMIT   = 3'd4
    } t_cfg_idx;

    localparam logic [15:0] FOM_LIMIT_RST    = 16'd205;
    localparam logic [15:0] ENERGY_LIMIT_RST = 16'd2000;
    localparam logic [14:0] PROMPT_WIN_RST   = 15'd30;
    localparam logic [15:0] COINC_WIN_RST    = 16'd20;
    localparam logic [3:0]  PAIR_LIMIT_RST   = 4'd12;
    localparam logic [3:0]  PAIR_LIMIT_CAP   = 4'd12;

    // Input operation codes
    localparam logic OP_HIT = 1'b0;
    localparam logic OP_EOE = 1'b1;

    typedef struct packed {
        logic [15:0] fom_limit;
        logic [15:0] energy_limit;
        logic [14:0] prompt_win;
        logic [15:0] coinc_win;
        logic [3:0]  pair_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] energy_p;
        logic signed [15:0] energy_t;
        logic signed [15:0] time_offset;
    } t_hit;

    typedef struct packed {
        logic              we;
        logic [HIT_AW-1:0] addr;
        t_hit              data;
    } t_mem_wr;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] n;
    } t_scan_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT_RD,
        S_CNT_EV,
        S_EM_RD,
        S_EM_EV
    } t_state;

endpackage

### hw/rtl/gpcf_in_if.sv
// Input channel of the gamma pair coincidence filter: one hit or end of event.
// No dependencies.
interface gpcf_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] energy_p;
    logic signed [15:0] energy_t;
    logic        [15:0] raw_energy;
    logic signed [15:0] time_offset;
    logic        [15:0] fom;

    modport source (
        output valid, op, energy_p, energy_t, raw_energy, time_offset, fom,
        input  ready
    );
    modport sink (
        input  valid, op, energy_p, energy_t, raw_energy, time_offset, fom,
        output ready
    );
endinterface

### hw/rtl/gpcf_out_if.sv
// Output channel of the gamma pair coincidence filter: one coincident pair.
// No dependencies.
interface gpcf_out_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  pair_count;
    logic signed [15:0] first_energy_p;
    logic signed [15:0] second_energy_p;
    logic signed [15:0] first_energy_t;
    logic signed [15:0] second_energy_t;
    logic               last;

    modport source (
        output valid, pair_count, first_energy_p, second_energy_p,
               first_energy_t, second_energy_t, last,
        input  ready
    );
    modport sink (
        input  valid, pair_count, first_energy_p, second_energy_p,
               first_energy_t, second_energy_t, last,
        output ready
    );
endinterface

### hw/rtl/gpcf_hit_mem.sv
// Hit store: one write port, two registered read ports.
// Depends on gpcf_pkg.
module gpcf_hit_mem (
    input  logic                          i_clk,
    input  gpcf_pkg::t_mem_wr             i_wr,
    input  logic [gpcf_pkg::HIT_AW-1:0]   i_rd_addr_a,
    input  logic [gpcf_pkg::HIT_AW-1:0]   i_rd_addr_b,
    output gpcf_pkg::t_hit                o_rd_a,
    output gpcf_pkg::t_hit                o_rd_b
);
    import gpcf_pkg::*;

    t_hit r_mem [MAX_HITS];
    t_hit r_rd_a;
    t_hit r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

### hw/rtl/gpcf_pair_seq.sv
// Pair sequencer: counts coincident pairs over the hit store, then emits them.
// Depends on gpcf_pkg, gpcf_out_if and the read ports of gpcf_hit_mem.
module gpcf_pair_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gpcf_pkg::t_cfg                i_cfg,
    input  gpcf_pkg::t_scan_req           i_req,
    output logic                          o_idle,
    output logic [gpcf_pkg::HIT_AW-1:0]   o_rd_addr_a,
    output logic [gpcf_pkg::HIT_AW-1:0]   o_rd_addr_b,
    input  gpcf_pkg::t_hit                i_rd_a,
    input  gpcf_pkg::t_hit                i_rd_b,
    gpcf_out_if.source                    o_out
);
    import gpcf_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_x, n_x;
    logic [CNT_W-1:0]   r_y, n_y;
    logic [3:0]         r_count, n_count;
    logic [3:0]         r_emit, n_emit;
    logic               r_out_valid, n_out_valid;
    logic               w_out_load;
    logic [3:0]         r_out_cnt;
    logic signed [15:0] r_out_ep_a, r_out_ep_b, r_out_et_a, r_out_et_b;
    logic               r_out_last;

    logic [3:0]         w_lim;
    logic [16:0]        w_diff;
    logic [16:0]        w_adiff;
    logic               w_pair;
    logic               w_scan_end;
    logic               w_y_wrap;
    logic [CNT_W-1:0]   w_adv_x, w_adv_y;
    logic               w_can_load;
    logic [3:0]         w_cnt_inc;
    logic               w_last;

    assign w_lim = (i_cfg.pair_limit > PAIR_LIMIT_CAP) ? PAIR_LIMIT_CAP : i_cfg.pair_limit;
    assign w_diff = {i_rd_a.time_offset[15], i_rd_a.time_offset}
                  - {i_rd_b.time_offset[15], i_rd_b.time_offset};
    assign w_adiff = w_diff[16] ? (~w_diff + 17'd1) : w_diff;
    assign w_pair = (r_x != r_y) && (w_adiff <= {1'b0, i_cfg.coinc_win});
    assign w_scan_end = (r_x == r_n);
    assign w_y_wrap = (r_y == r_n - CNT_W'(1));
    assign w_adv_x = w_y_wrap ? r_x + CNT_W'(1) : r_x;
    assign w_adv_y = w_y_wrap ? '0 : r_y + CNT_W'(1);
    assign w_can_load = !r_out_valid || o_out.ready;
    assign w_cnt_inc = r_count + 4'd1;
    assign w_last = (r_emit + 4'd1) == r_count;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) n_state = S_CNT_RD;
            end
            S_CNT_RD: begin
                if (w_scan_end) n_state = (r_count == 4'd0) ? S_IDLE : S_EM_RD;
                else            n_state = S_CNT_EV;
            end
            S_CNT_EV: begin
                // Drop the whole event once the pair limit is reached
                if (w_pair && (w_cnt_inc >= w_lim)) n_state = S_IDLE;
                else                                n_state = S_CNT_RD;
            end
            S_EM_RD: begin
                n_state = S_EM_EV;
            end
            S_EM_EV: begin
                if (!w_pair)        n_state = S_EM_RD;
                else if (w_can_load) n_state = w_last ? S_IDLE : S_EM_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Scan indices, counters and output register control
    always_comb begin
        n_n         = r_n;
        n_x         = r_x;
        n_y         = r_y;
        n_count     = r_count;
        n_emit      = r_emit;
        n_out_valid = r_out_valid && !o_out.ready;
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_n     = i_req.n;
                    n_x     = '0;
                    n_y     = '0;
                    n_count = '0;
                end
            end
            S_CNT_RD: begin
                if (w_scan_end) begin
                    n_x    = '0;
                    n_y    = '0;
                    n_emit = '0;
                end
            end
            S_CNT_EV: begin
                n_x = w_adv_x;
                n_y = w_adv_y;
                if (w_pair) n_count = w_cnt_inc;
            end
            S_EM_RD: begin
            end
            S_EM_EV: begin
                if (!w_pair) begin
                    n_x = w_adv_x;
                    n_y = w_adv_y;
                end else if (w_can_load) begin
                    n_x         = w_adv_x;
                    n_y         = w_adv_y;
                    n_emit      = r_emit + 4'd1;
                    n_out_valid = 1'b1;
                    w_out_load  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_count     <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_x         <= n_x;
            r_y         <= n_y;
            r_count     <= n_count;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_cnt  <= r_count;
            r_out_ep_a <= i_rd_a.energy_p;
            r_out_ep_b <= i_rd_b.energy_p;
            r_out_et_a <= i_rd_a.energy_t;
            r_out_et_b <= i_rd_b.energy_t;
            r_out_last <= w_last;
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_rd_addr_a = r_x[HIT_AW-1:0];
    assign o_rd_addr_b = r_y[HIT_AW-1:0];

    assign o_out.valid           = r_out_valid;
    assign o_out.pair_count      = r_out_cnt;
    assign o_out.first_energy_p  = r_out_ep_a;
    assign o_out.second_energy_p = r_out_ep_b;
    assign o_out.first_energy_t  = r_out_et_a;
    assign o_out.second_energy_t = r_out_et_b;
    assign o_out.last            = r_out_last;

    a_out_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cnt != 4'd0) && (r_out_cnt < PAIR_LIMIT_CAP))
        else $error("pair result with out-of-range pair count");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_x <= r_n))
        else $error("scan index ran past the hit count");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_RD || r_state == S_EM_EV) |-> (r_emit < r_count))
        else $error("emitted more pairs than counted");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || o_out.ready))
        else $error("pending pair result overwritten");

endmodule

### hw/rtl/gamma_pair_coincidence_filter_unit.sv
// Top level of the gamma pair coincidence filter: hit cuts, config registers,
// hit store and pair sequencer. Depends on gpcf_pkg, gpcf_in_if, gpcf_out_if,
// gpcf_hit_mem and gpcf_pair_seq.
//
// The unit collects the hits of one event and, on the end-of-event transaction,
// emits every ordered pair of distinct kept hits whose time offsets lie within
// the coincidence window, each carrying the event's pair count and the two
// energies of both hits, with last set on the final pair. A hit is kept when
// fom, raw energy and |time offset| are all within their limits; at most 16
// hits are stored and later ones are dropped. Events whose pair count reaches
// the pair limit (capped at twelve; zero drops every event) give nothing. End
// of event walks the store twice through its two-port hit memory, reading and
// then evaluating each ordered index pair: once to count the pairs of the kept
// hits and once more to emit them, stalling while the output sink holds off.
// The input is not ready during that walk; a finished pair waits in the output
// register without holding back the next event's hits. Write configuration
// only while the unit is idle.
module gamma_pair_coincidence_filter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gpcf_in_if.sink                           i_in,
    gpcf_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [gpcf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gpcf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import gpcf_pkg::*;

    t_cfg             r_cfg;
    logic [CNT_W-1:0] r_hit_count;

    logic             w_idle;
    logic             w_accept;
    logic [15:0]      w_abs_dt;
    logic             w_keep;
    t_mem_wr          w_wr;
    t_scan_req        w_req;
    logic [HIT_AW-1:0] w_rd_addr_a, w_rd_addr_b;
    t_hit             w_rd_a, w_rd_b;

    // Configuration registers; writes to unused indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fom_limit    <= FOM_LIMIT_RST;
            r_cfg.energy_limit <= ENERGY_LIMIT_RST;
            r_cfg.prompt_win   <= PROMPT_WIN_RST;
            r_cfg.coinc_win    <= COINC_WIN_RST;
            r_cfg.pair_limit   <= PAIR_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FOM_LIMIT:    r_cfg.fom_limit    <= i_cfg_wdata;
                CFG_ENERGY_LIMIT: r_cfg.energy_limit <= i_cfg_wdata;
                CFG_PROMPT_WIN:   r_cfg.prompt_win   <= i_cfg_wdata[14:0];
                CFG_COINC_WIN:    r_cfg.coinc_win    <= i_cfg_wdata;
                CFG_PAIR_LIMIT:   r_cfg.pair_limit   <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Accept new transactions only while no event is being walked
    assign i_in.ready = w_idle;
    assign w_accept   = i_in.valid && w_idle;

    // Magnitude of the time offset; the most negative offset maps to 32768
    assign w_abs_dt = i_in.time_offset[15] ? (~i_in.time_offset + 16'd1)
                                           : i_in.time_offset;

    assign w_keep = (i_in.fom <= r_cfg.fom_limit)
                 && (i_in.raw_energy <= r_cfg.energy_limit)
                 && (w_abs_dt <= {1'b0, r_cfg.prompt_win})
                 && (r_hit_count < CNT_W'(MAX_HITS));

    assign w_wr.we                = w_accept && (i_in.op == OP_HIT) && w_keep;
    assign w_wr.addr              = r_hit_count[HIT_AW-1:0];
    assign w_wr.data.energy_p     = i_in.energy_p;
    assign w_wr.data.energy_t     = i_in.energy_t;
    assign w_wr.data.time_offset  = i_in.time_offset;

    // Hand the hit count to the sequencer at end of event and empty the store
    assign w_req.start = w_accept && (i_in.op == OP_EOE);
    assign w_req.n     = r_hit_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_count <= '0;
        end else if (w_req.start) begin
            r_hit_count <= '0;
        end else if (w_wr.we) begin
            r_hit_count <= r_hit_count + CNT_W'(1);
        end
    end

    gpcf_hit_mem u_hit_mem (
        .i_clk       (i_clk),
        .i_wr        (w_wr),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_a      (w_rd_a),
        .o_rd_b      (w_rd_b)
    );

    gpcf_pair_seq u_pair_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req       (w_req),
        .o_idle      (w_idle),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b),
        .i_rd_a      (w_rd_a),
        .i_rd_b      (w_rd_b),
        .o_out       (o_out)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit_count <= CNT_W'(MAX_HITS))
        else $error("hit count exceeds store depth");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.we |-> w_idle)
        else $error("hit store written during a pair walk");

    a_eoe_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |=> (r_hit_count == '0))
        else $error("hit count not cleared at end of event");

endmodule
